[sv/capacitive_touch_key_detector_unit_defines.svh]
// assertion helpers shared by the touch key detector
`ifndef CAPACITIVE_TOUCH_KEY_DETECTOR_UNIT_DEFINES_SVH
`define CAPACITIVE_TOUCH_KEY_DETECTOR_UNIT_DEFINES_SVH

// consequence holds in the same cycle
`define CTK_ASSERT_SAME(label, ante, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (conseq)) \
	else $error(msg);

// consequence holds in the following cycle
`define CTK_ASSERT_NEXT(label, ante, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (conseq)) \
	else $error(msg);

`endif

[sv/ctk_pkg.sv]
`timescale 1ns / 1ps
package ctk_pkg;

	localparam int CAL_SAMPLES_DEF    = 10;
	localparam int TRIM_EACH_SIDE_DEF = 2;
	localparam int SCAN_SAMPLES_DEF   = 3;

	localparam int SAMPLE_W    = 16;
	localparam int MARGIN_W    = 16;
	localparam int RATIO_W     = 4;
	localparam int CFG_W       = 16;
	localparam int CFG_AW      = 1;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * SAMPLE_W - 2;

	localparam logic [MARGIN_W-1:0] MARGIN_RST = 16'd100;
	localparam logic [RATIO_W-1:0]  RATIO_RST  = 4'd10;
	localparam logic [SAMPLE_W-1:0] HALF_SCALE = 16'h7fff;

	localparam logic [CFG_AW-1:0] REG_PRESS_MARGIN = 1'b0;
	localparam logic [CFG_AW-1:0] REG_UPPER_RATIO  = 1'b1;

	localparam logic OP_CAL    = 1'b0;
	localparam logic OP_SCAN   = 1'b1;
	localparam logic KIND_CAL  = 1'b0;
	localparam logic KIND_SCAN = 1'b1;

	typedef logic [3:0] step_t;

	localparam step_t ST_WAIT     = 4'd0;
	localparam step_t ST_DISPATCH = 4'd1;
	localparam step_t ST_STORE    = 4'd2;
	localparam step_t ST_INIT     = 4'd3;
	localparam step_t ST_PIV_RD   = 4'd4;
	localparam step_t ST_PIV_LD   = 4'd5;
	localparam step_t ST_RANK     = 4'd6;
	localparam step_t ST_ACCUM    = 4'd7;
	localparam step_t ST_RCP_MUL  = 4'd8;
	localparam step_t ST_DIV      = 4'd9;
	localparam step_t ST_BASE     = 4'd10;
	localparam step_t ST_PEAK     = 4'd11;
	localparam step_t ST_EVAL     = 4'd12;
	localparam step_t ST_EMIT     = 4'd13;
	localparam step_t ST_RETURN   = 4'd14;

	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_ACCEPT,
		UOP_STORE,
		UOP_INIT,
		UOP_PIV_RD,
		UOP_PIV_LD,
		UOP_RANK,
		UOP_ACCUM,
		UOP_RCP_MUL,
		UOP_DIV,
		UOP_BASE,
		UOP_PEAK,
		UOP_EVAL,
		UOP_EMIT
	} uop_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NOT_FIRE,
		C_IS_SCAN,
		C_NOT_LAST,
		C_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		step_t target;
	} ctl_t;

	typedef struct packed {
		logic is_scan;
		logic last;
		logic more;
	} dp_stat_t;

	typedef struct packed {
		logic                kind;
		logic [SAMPLE_W-1:0] baseline;
		logic                baseline_high;
		logic [SAMPLE_W-1:0] peak;
		logic                pressed;
	} res_t;

	// jump taken when cond holds, otherwise fall through to the next step
	function automatic ctl_t ucode_rom(input step_t addr);
		ctl_t w;
		begin
			unique case (addr)
				ST_WAIT:     w = '{UOP_ACCEPT,   C_NOT_FIRE, ST_WAIT};
				ST_DISPATCH: w = '{UOP_NOP,      C_IS_SCAN,  ST_PEAK};
				ST_STORE:    w = '{UOP_STORE,    C_NOT_LAST, ST_WAIT};
				ST_INIT:     w = '{UOP_INIT,     C_ALWAYS,   ST_PIV_RD};
				ST_PIV_RD:   w = '{UOP_PIV_RD,   C_ALWAYS,   ST_PIV_LD};
				ST_PIV_LD:   w = '{UOP_PIV_LD,   C_ALWAYS,   ST_RANK};
				ST_RANK:     w = '{UOP_RANK,     C_MORE,     ST_RANK};
				ST_ACCUM:    w = '{UOP_ACCUM,    C_MORE,     ST_PIV_RD};
				ST_RCP_MUL:  w = '{UOP_RCP_MUL,  C_ALWAYS,   ST_DIV};
				ST_DIV:      w = '{UOP_DIV,      C_ALWAYS,   ST_BASE};
				ST_BASE:     w = '{UOP_BASE,     C_ALWAYS,   ST_EMIT};
				ST_PEAK:     w = '{UOP_PEAK,     C_NOT_LAST, ST_WAIT};
				ST_EVAL:     w = '{UOP_EVAL,     C_ALWAYS,   ST_EMIT};
				ST_EMIT:     w = '{UOP_EMIT,     C_OUT_BUSY, ST_EMIT};
				ST_RETURN:   w = '{UOP_NOP,      C_ALWAYS,   ST_WAIT};
				default:     w = '{UOP_NOP,      C_ALWAYS,   ST_WAIT};
			endcase
			return w;
		end
	endfunction

endpackage

[sv/ctk_seq.sv]
`timescale 1ns / 1ps
module ctk_seq
	import ctk_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     out_busy,
	input  dp_stat_t stat,
	output ctl_t     ctl
);

	step_t pc_q;
	logic  jump;

	assign ctl = ucode_rom(pc_q);

	always_comb begin
		unique case (ctl.cond)
			C_ALWAYS:   jump = 1'b1;
			C_NOT_FIRE: jump = !in_fire;
			C_IS_SCAN:  jump = stat.is_scan;
			C_NOT_LAST: jump = !stat.last;
			C_MORE:     jump = stat.more;
			C_OUT_BUSY: jump = out_busy;
			default:    jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_WAIT;
		end else begin
			pc_q <= jump ? ctl.target : step_t'(pc_q + 4'd1);
		end
	end

endmodule

[sv/ctk_dp.sv]
`timescale 1ns / 1ps
module ctk_dp
	import ctk_pkg::*;
#(
	parameter int CAL_SAMPLES    = CAL_SAMPLES_DEF,
	parameter int TRIM_EACH_SIDE = TRIM_EACH_SIDE_DEF,
	parameter int SCAN_SAMPLES   = SCAN_SAMPLES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  uop_t                uop,
	input  logic                in_fire,
	input  logic                in_op,
	input  logic [SAMPLE_W-1:0] in_sample,
	input  logic                in_rearm,
	input  logic [MARGIN_W-1:0] margin,
	input  logic [RATIO_W-1:0]  ratio,
	output dp_stat_t            stat,
	output res_t                res
);

	localparam int AW       = $clog2(CAL_SAMPLES);
	localparam int CW       = $clog2(CAL_SAMPLES + 1);
	localparam int SCW      = $clog2(SCAN_SAMPLES + 1);
	localparam int TRIM_EFF = (2 * TRIM_EACH_SIDE >= CAL_SAMPLES) ?
		(CAL_SAMPLES - 1) / 2 : TRIM_EACH_SIDE;
	localparam int KEEP     = CAL_SAMPLES - 2 * TRIM_EFF;
	localparam int SUM_W    = SAMPLE_W + CW;
	// floor(sum / KEEP) = (sum * RCP_M) >> RCP_SH, exact for every sum below 2**SUM_W
	localparam int RCP_SH   = SUM_W + $clog2(KEEP);
	localparam int RCP_W    = SUM_W + 1;
	localparam int PROD_W   = SUM_W + RCP_W;
	localparam longint RCP_M_INT = ((longint'(1) << RCP_SH) + longint'(KEEP) - 1) /
		longint'(KEEP);

	localparam logic [AW-1:0]    LAST_IDX  = AW'(CAL_SAMPLES - 1);
	localparam logic [CW-1:0]    RANK_LO   = CW'(TRIM_EFF);
	localparam logic [CW-1:0]    RANK_HI   = CW'(CAL_SAMPLES - TRIM_EFF);
	localparam logic [CW-1:0]    J_END     = CW'(CAL_SAMPLES);
	localparam logic [SCW-1:0]   SCAN_LAST = SCW'(SCAN_SAMPLES - 1);
	localparam logic [RCP_W-1:0] RCP_M     = RCP_W'(RCP_M_INT);

	logic [SAMPLE_W-1:0] calib_mem [CAL_SAMPLES];
	logic [SAMPLE_W-1:0] rd_data_q;
	logic [AW-1:0]       rd_addr;

	logic                op_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                rearm_q;

	logic [AW-1:0]       calib_cnt_q;
	logic [SCW-1:0]      scan_cnt_q;
	logic [SAMPLE_W-1:0] scan_peak_q;
	logic [SAMPLE_W-1:0] base_q;
	logic                held_q;

	logic [AW-1:0]       i_q;
	logic [CW-1:0]       j_q;
	logic [AW-1:0]       jp_q;
	logic [AW-1:0]       rank_q;

	logic [SAMPLE_W-1:0] pivot_q;
	logic [SUM_W-1:0]    sum_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SAMPLE_W-1:0] pk_q;
	logic                kind_q;
	logic [SAMPLE_W-1:0] res_peak_q;
	logic                pressed_q;

	logic                cal_last;
	logic                grp_last;
	logic                less;
	logic                in_keep;
	logic [SAMPLE_W-1:0] scan_max;
	logic [SAMPLE_W:0]   lo_bound;
	logic [SAMPLE_W+RATIO_W-1:0] hi_bound;
	logic                touch;
	logic                held_eff;

	assign cal_last = (calib_cnt_q == LAST_IDX);
	assign grp_last = (scan_cnt_q == SCAN_LAST);

	// ties broken by store index so ranks form the sorted order
	assign less     = (rd_data_q < pivot_q) || ((rd_data_q == pivot_q) && (jp_q < i_q));
	assign in_keep  = (CW'(rank_q) >= RANK_LO) && (CW'(rank_q) < RANK_HI);

	assign scan_max = (sample_q > scan_peak_q) ? sample_q : scan_peak_q;

	assign lo_bound = {1'b0, base_q} + {1'b0, margin};
	assign hi_bound = {{SAMPLE_W{1'b0}}, ratio} * {{RATIO_W{1'b0}}, base_q};
	assign touch    = ({1'b0, pk_q} > lo_bound) &&
		({{RATIO_W{1'b0}}, pk_q} < hi_bound);
	assign held_eff = held_q && !rearm_q;

	always_comb begin
		if (uop == UOP_PIV_RD) begin
			rd_addr = i_q;
		end else if (j_q == J_END) begin
			rd_addr = '0;
		end else begin
			rd_addr = j_q[AW-1:0];
		end
	end

	always_comb begin
		stat.is_scan = (op_q == OP_SCAN);
		stat.last    = (uop == UOP_STORE) ? cal_last : grp_last;
		unique case (uop)
			UOP_RANK:  stat.more = (jp_q != LAST_IDX);
			UOP_ACCUM: stat.more = (i_q != LAST_IDX);
			default:   stat.more = 1'b0;
		endcase
	end

	assign res.kind          = kind_q;
	assign res.baseline      = base_q;
	assign res.baseline_high = (base_q > HALF_SCALE);
	assign res.peak          = res_peak_q;
	assign res.pressed       = pressed_q;

	always_ff @(posedge clk) begin
		if (uop == UOP_STORE) begin
			calib_mem[calib_cnt_q] <= sample_q;
		end
		rd_data_q <= calib_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_cnt_q <= '0;
			scan_cnt_q  <= '0;
			scan_peak_q <= '0;
			base_q      <= '0;
			held_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			jp_q        <= '0;
			rank_q      <= '0;
		end else begin
			unique case (uop)
				UOP_STORE: begin
					calib_cnt_q <= cal_last ? '0 : AW'(calib_cnt_q + 1'b1);
				end
				UOP_INIT: begin
					i_q <= '0;
				end
				UOP_PIV_RD: begin
					j_q <= '0;
				end
				UOP_PIV_LD: begin
					j_q    <= CW'(1);
					jp_q   <= '0;
					rank_q <= '0;
				end
				UOP_RANK: begin
					rank_q <= AW'(rank_q + AW'(less));
					jp_q   <= j_q[AW-1:0];
					j_q    <= CW'(j_q + 1'b1);
				end
				UOP_ACCUM: begin
					i_q <= AW'(i_q + 1'b1);
				end
				UOP_BASE: begin
					base_q <= sum_q[SAMPLE_W-1:0];
				end
				UOP_PEAK: begin
					scan_cnt_q  <= grp_last ? '0 : SCW'(scan_cnt_q + 1'b1);
					scan_peak_q <= grp_last ? '0 : scan_max;
				end
				UOP_EVAL: begin
					held_q <= touch;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= in_op;
			sample_q <= in_sample;
			rearm_q  <= in_rearm;
		end
		unique case (uop)
			UOP_INIT: begin
				sum_q <= '0;
			end
			UOP_PIV_LD: begin
				pivot_q <= rd_data_q;
			end
			UOP_ACCUM: begin
				if (in_keep) begin
					sum_q <= SUM_W'(sum_q + SUM_W'(pivot_q));
				end
			end
			UOP_RCP_MUL: begin
				prod_q <= {{RCP_W{1'b0}}, sum_q} * {{SUM_W{1'b0}}, RCP_M};
			end
			UOP_DIV: begin
				// quotient by the kept count, taken from the scaled product
				sum_q <= SUM_W'(prod_q[RCP_SH +: SAMPLE_W]);
			end
			UOP_BASE: begin
				kind_q     <= KIND_CAL;
				res_peak_q <= '0;
				pressed_q  <= 1'b0;
			end
			UOP_PEAK: begin
				pk_q <= scan_max;
			end
			UOP_EVAL: begin
				kind_q     <= KIND_SCAN;
				res_peak_q <= pk_q;
				pressed_q  <= touch && !held_eff;
			end
			default: begin
			end
		endcase
	end

endmodule

[sv/capacitive_touch_key_detector_unit.sv]
// one word at a time, run by a microcode sequencer (program rom, step counter, jumps)
// scan word: accept, dispatch, peak; closing a group adds eval, then emit registers the result
//   (waiting while the output is busy) and return; the closing calibration word runs store,
//   a rank-counting pass over the sample store, kept sum, reciprocal divide, baseline, emit
// other calibration words: accept, dispatch, store; a held result does not block the next word
// arst_n clears control, baseline, running peak, press hold, sets config defaults; store not cleared
`timescale 1ns / 1ps
`include "capacitive_touch_key_detector_unit_defines.svh"
module capacitive_touch_key_detector_unit
	import ctk_pkg::*;
#(
	parameter int CAL_SAMPLES    = CAL_SAMPLES_DEF,
	parameter int TRIM_EACH_SIDE = TRIM_EACH_SIDE_DEF,
	parameter int SCAN_SAMPLES   = SCAN_SAMPLES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample[15:0], rearm[16], zero pad
	input  logic                   s_axis_tuser,   // op
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // baseline, baseline_high, peak, pressed, pad
	output logic                   m_axis_tuser,   // result_kind
	input  logic                   cfg_we,
	input  logic [CFG_AW-1:0]      cfg_addr,
	input  logic [CFG_W-1:0]       cfg_wdata
);

	logic [MARGIN_W-1:0] margin_q;
	logic [RATIO_W-1:0]  ratio_q;
	logic                m_valid_q;
	res_t                out_res_q;

	ctl_t     ctl;
	dp_stat_t stat;
	res_t     res;
	logic     in_fire;
	logic     out_busy;
	logic     out_load;

	assign s_axis_tready = (ctl.uop == UOP_ACCEPT);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_busy      = m_valid_q && !m_axis_tready;
	assign out_load      = (ctl.uop == UOP_EMIT) && !out_busy;

	ctk_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_busy (out_busy),
		.stat     (stat),
		.ctl      (ctl)
	);

	ctk_dp #(
		.CAL_SAMPLES    (CAL_SAMPLES),
		.TRIM_EACH_SIDE (TRIM_EACH_SIDE),
		.SCAN_SAMPLES   (SCAN_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.uop       (ctl.uop),
		.in_fire   (in_fire),
		.in_op     (s_axis_tuser),
		.in_sample (s_axis_tdata[SAMPLE_W-1:0]),
		.in_rearm  (s_axis_tdata[SAMPLE_W]),
		.margin    (margin_q),
		.ratio     (ratio_q),
		.stat      (stat),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q  <= MARGIN_RST;
			ratio_q   <= RATIO_RST;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_PRESS_MARGIN: margin_q <= cfg_wdata[MARGIN_W-1:0];
					REG_UPPER_RATIO:  ratio_q  <= cfg_wdata[RATIO_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_res_q.kind;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_res_q.pressed, out_res_q.peak,
		out_res_q.baseline_high, out_res_q.baseline};

	`CTK_ASSERT_SAME(a_press_on_scan, m_valid_q && out_res_q.pressed, out_res_q.kind == KIND_SCAN, "press flagged on a calibration word")
	`CTK_ASSERT_SAME(a_cal_peak_zero, m_valid_q && out_res_q.kind == KIND_CAL, out_res_q.peak == '0 && !out_res_q.pressed, "calibration word carries scan data")
	`CTK_ASSERT_NEXT(a_one_word_at_a_time, in_fire, !s_axis_tready, "input taken again right after accept")
	`CTK_ASSERT_NEXT(a_load_shows, out_load, m_valid_q, "loaded result not presented")

endmodule
